>>> rtl/core/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// Shared constants and types for the I2C EEPROM slave model.
// ----------------------------------------------------------------------------
package i2cee_pkg;

  localparam int AddrW = 12;
  localparam int ByteW = 8;

  // request codes
  localparam logic [1:0] ActCtrl = 2'd0;
  localparam logic [1:0] ActBuf  = 2'd1;
  localparam logic [1:0] ActLoad = 2'd2;

  // device codes
  localparam logic [7:0] DevWrite = 8'hA0;
  localparam logic [7:0] DevRead  = 8'hA1;

  localparam logic [AddrW-1:0] AddrMask = 12'hFFF;

  // control register bits
  localparam logic [7:0] BitAcken = 8'h10;
  localparam logic [7:0] BitRcen  = 8'h08;
  localparam logic [7:0] BitPen   = 8'h04;
  localparam logic [7:0] BitRsen  = 8'h02;
  localparam logic [7:0] BitSen   = 8'h01;

  localparam logic [7:0] CondAny  = BitAcken | BitRcen | BitPen | BitRsen | BitSen;
  localparam logic [7:0] CondClr  = BitAcken | BitPen | BitRsen | BitSen;
  localparam logic [7:0] CondIdle = BitPen | BitRsen;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] wdata;
  } mem_req_t;

endpackage

>>> rtl/core/i2cee_ram.sv
// ----------------------------------------------------------------------------
// i2cee_ram
// Single-port byte storage, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module i2cee_ram #(
  parameter int MEMORY_BYTES = 4096
) (
  input  logic                       clk_i,
  input  i2cee_pkg::mem_req_t        req_i,
  output logic [i2cee_pkg::ByteW-1:0] rdata_o
);

  localparam int Aw = $clog2(MEMORY_BYTES);

  logic [i2cee_pkg::ByteW-1:0] mem [MEMORY_BYTES];
  logic [i2cee_pkg::ByteW-1:0] rdata_q;
  logic [Aw-1:0]               idx;

  assign idx = Aw'(req_i.addr);

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[idx] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[idx];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/i2cee_ctrl.sv
// ----------------------------------------------------------------------------
// i2cee_ctrl
// Protocol phase machine, address pointer and result registers.
// ----------------------------------------------------------------------------
module i2cee_ctrl #(
  parameter int MEMORY_BYTES = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [1:0]                   action_i,
  input  logic [i2cee_pkg::ByteW-1:0]  data_i,
  input  logic [i2cee_pkg::AddrW-1:0]  load_address_i,
  output i2cee_pkg::mem_req_t          req_o,
  output logic                         done_o,
  output logic [i2cee_pkg::ByteW-1:0]  control_stored_o,
  output logic                         read_valid_o,
  output logic                         interrupt_flag_o,
  output logic                         bad_address_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhHigh = 2'd1;
  localparam logic [1:0] PhLow  = 2'd2;
  localparam logic [1:0] PhData = 2'd3;

  localparam bit MemBig   = (MEMORY_BYTES >= 4096);
  localparam int RedSteps = MemBig ? 1 :
                            $clog2((4096 + MEMORY_BYTES - 1) / MEMORY_BYTES) + 1;

  // modulo by the memory size, conditional subtract of shifted sizes
  function automatic logic [i2cee_pkg::AddrW-1:0] wrap_addr(
    input logic [i2cee_pkg::AddrW-1:0] a
  );
    logic [15:0] r;
    int          lim;
    r = 16'(a);
    if (!MemBig) begin
      for (int k = RedSteps - 1; k >= 0; k--) begin
        lim = MEMORY_BYTES << k;
        if (int'(r) >= lim) begin
          r = r - 16'(lim);
        end
      end
    end
    return r[i2cee_pkg::AddrW-1:0];
  endfunction

  logic [1:0]                  phase_q, phase_d;
  logic [i2cee_pkg::AddrW-1:0] ptr_q, ptr_d;
  logic [i2cee_pkg::AddrW:0]   ptr_inc;
  logic                        done_q;
  logic [i2cee_pkg::ByteW-1:0] ctl_q, ctl_d;
  logic                        rvalid_q, rvalid_d;
  logic                        irq_q, irq_d;
  logic                        bad_q, bad_d;

  assign ptr_inc = {1'b0, ptr_q} + 13'd1;

  always_comb begin
    phase_d  = phase_q;
    ptr_d    = ptr_q;
    req_o    = '0;
    ctl_d    = '0;
    rvalid_d = 1'b0;
    irq_d    = 1'b0;
    bad_d    = 1'b0;
    if (accept_i) begin
      unique case (action_i)
        i2cee_pkg::ActCtrl: begin
          ctl_d = data_i;
          if ((data_i & i2cee_pkg::CondAny) != '0) begin
            if ((data_i & i2cee_pkg::CondIdle) != '0) begin
              phase_d = PhIdle;
            end
            irq_d = 1'b1;
            ctl_d = data_i & ~i2cee_pkg::CondClr;
          end
        end
        i2cee_pkg::ActBuf: begin
          irq_d = 1'b1;
          unique case (phase_q)
            PhIdle: begin
              if (data_i == i2cee_pkg::DevRead) begin
                rvalid_d   = 1'b1;
                req_o.re   = 1'b1;
                req_o.addr = wrap_addr(ptr_q);
                if (ptr_inc[i2cee_pkg::AddrW] || (int'(ptr_inc) >= MEMORY_BYTES)) begin
                  ptr_d = '0;
                end else begin
                  ptr_d = ptr_inc[i2cee_pkg::AddrW-1:0];
                end
              end else if (data_i == i2cee_pkg::DevWrite) begin
                phase_d = PhHigh;
              end else begin
                bad_d = 1'b1;
              end
            end
            PhHigh: begin
              ptr_d   = {data_i[3:0], 8'h00} & i2cee_pkg::AddrMask;
              phase_d = PhLow;
            end
            PhLow: begin
              ptr_d   = (ptr_q | {4'h0, data_i}) & i2cee_pkg::AddrMask;
              phase_d = PhData;
            end
            PhData: begin
              req_o.we    = 1'b1;
              req_o.addr  = wrap_addr(ptr_q);
              req_o.wdata = data_i;
              phase_d     = PhIdle;
            end
            default: begin
              phase_d = PhIdle;
            end
          endcase
        end
        i2cee_pkg::ActLoad: begin
          req_o.we    = 1'b1;
          req_o.addr  = wrap_addr(load_address_i);
          req_o.wdata = data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      ptr_q    <= '0;
      done_q   <= 1'b0;
      rvalid_q <= 1'b0;
      irq_q    <= 1'b0;
      bad_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      ptr_q    <= ptr_d;
      done_q   <= accept_i;
      rvalid_q <= rvalid_d;
      irq_q    <= irq_d;
      bad_q    <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q <= ctl_d;
  end

  assign done_o           = done_q;
  assign control_stored_o = ctl_q;
  assign read_valid_o     = rvalid_q;
  assign interrupt_flag_o = irq_q;
  assign bad_address_o    = bad_q;

endmodule

>>> rtl/core/i2c_eeprom_slave_model.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_slave_model
// I2C serial EEPROM (12-bit word address) seen through a master's registers.
// ----------------------------------------------------------------------------
// One request is taken per clock (busy stays low); its result appears on
// the result ports with done_o high in the cycle after the request, set by
// the registered read of the storage memory. Results cannot be held off by
// the receiver. Storage contents are undefined until written or preloaded;
// there is no clearing pass after reset.
module i2c_eeprom_slave_model #(
  parameter int MEMORY_BYTES = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action_i,
  input  logic [i2cee_pkg::ByteW-1:0]  data_i,
  input  logic [i2cee_pkg::AddrW-1:0]  load_address_i,
  output logic                         done_o,
  output logic [i2cee_pkg::ByteW-1:0]  control_stored_o,
  output logic                         read_valid_o,
  output logic [i2cee_pkg::ByteW-1:0]  read_data_o,
  output logic                         interrupt_flag_o,
  output logic                         bad_address_o
);

  i2cee_pkg::mem_req_t         req;
  logic [i2cee_pkg::ByteW-1:0] rdata;
  logic                        accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  i2cee_ctrl #(
    .MEMORY_BYTES(MEMORY_BYTES)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .action_i        (action_i),
    .data_i          (data_i),
    .load_address_i  (load_address_i),
    .req_o           (req),
    .done_o          (done_o),
    .control_stored_o(control_stored_o),
    .read_valid_o    (read_valid_o),
    .interrupt_flag_o(interrupt_flag_o),
    .bad_address_o   (bad_address_o)
  );

  i2cee_ram #(
    .MEMORY_BYTES(MEMORY_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .req_i  (req),
    .rdata_o(rdata)
  );

  assign read_data_o = read_valid_o ? rdata : '0;

endmodule

>>> tb/sv/i2cee_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cee_checker
// Watches the request and result channels of the I2C EEPROM slave model,
// keeps its own copy of the protocol phase, address pointer and storage,
// works out the result of each accepted request and compares every strobed
// result field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module i2cee_checker
  import i2cee_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       action_i,
  input  logic [ByteW-1:0] data_i,
  input  logic [AddrW-1:0] load_address_i,
  input  logic             done_o,
  input  logic [ByteW-1:0] control_stored_o,
  input  logic             read_valid_o,
  input  logic [ByteW-1:0] read_data_o,
  input  logic             interrupt_flag_o,
  input  logic             bad_address_o,
  output int               errors,
  output int               pending
);

  typedef enum logic [1:0] {PhIdle, PhHigh, PhLow, PhData} bus_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] ctl;
    logic             rvalid;
    logic [ByteW-1:0] rdata;
    logic             irq;
    logic             bad;
  } access_resp_t;

  bus_phase_e       phase;
  logic [AddrW-1:0] ptr;
  logic [ByteW-1:0] mem [MEM_BYTES];
  access_resp_t     resp_due [$];

  function automatic access_resp_t eeprom_access(input logic [1:0] act,
                                                 input logic [ByteW-1:0] d,
                                                 input logic [AddrW-1:0] la);
    access_resp_t r;
    int nxt;
    r = '0;
    case (act)
      ActCtrl: begin
        r.ctl = d;
        if ((d & CondAny) != 0) begin
          if ((d & CondIdle) != 0) phase = PhIdle;
          r.irq = 1'b1;
          r.ctl = d & ~CondClr;
        end
      end
      ActBuf: begin
        r.irq = 1'b1;
        case (phase)
          PhIdle: begin
            if (d == DevRead) begin
              r.rvalid = 1'b1;
              r.rdata  = mem[ptr % MEM_BYTES];
              nxt = int'(ptr) + 1;
              if (nxt >= MEM_BYTES || nxt > int'(AddrMask)) nxt = 0;
              ptr = nxt[AddrW-1:0];
            end else if (d == DevWrite) begin
              phase = PhHigh;
            end else begin
              r.bad = 1'b1;
            end
          end
          PhHigh: begin
            ptr   = (AddrW'(d) << 8) & AddrMask;
            phase = PhLow;
          end
          PhLow: begin
            ptr   = (ptr | AddrW'(d)) & AddrMask;
            phase = PhData;
          end
          default: begin
            mem[ptr % MEM_BYTES] = d;
            phase = PhIdle;
          end
        endcase
      end
      ActLoad: mem[la % MEM_BYTES] = d;
      default: ;
    endcase
    return r;
  endfunction

  function automatic int field_bad(input string name, input int exp_v, input int got_v);
    if (exp_v == got_v) return 0;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    return 1;
  endfunction

  always @(posedge clk_i) begin
    access_resp_t want;
    int n_bad;
    n_bad = 0;
    if (!rst_ni) begin
      phase = PhIdle;
      ptr   = '0;
      resp_due.delete();
      pending <= 0;
      errors  <= 0;
    end else begin
      if (done_o) begin
        if (resp_due.size() == 0) begin
          $display("%0t: result with no request outstanding, actual ctl %0h rv %0b rd %0h",
                   $time, control_stored_o, read_valid_o, read_data_o);
          n_bad = 1;
        end else begin
          want = resp_due.pop_front();
          n_bad += field_bad("control_stored", want.ctl, control_stored_o);
          n_bad += field_bad("read_valid", want.rvalid, read_valid_o);
          n_bad += field_bad("read_data", want.rdata, read_data_o);
          n_bad += field_bad("interrupt_flag", want.irq, interrupt_flag_o);
          n_bad += field_bad("bad_address", want.bad, bad_address_o);
        end
      end
      if (start && !busy) resp_due.push_back(eeprom_access(action_i, data_i, load_address_i));
      pending <= resp_due.size();
      errors  <= errors + n_bad;
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the I2C EEPROM slave model: a directed pass over
// control bits, write/read transactions, address wrap, bad device codes and
// unused requests, then random bursts of well-formed transactions mixed with
// noise and aborted sequences. Reads only touch storage already written.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cee_pkg::*;

  localparam int         MemBytes    = 4096;
  localparam int         RandomItems = 900;
  localparam logic [1:0] ActNone     = 2'd3;

  logic             clk_i;
  logic             rst_ni         = 1'b0;
  logic             start          = 1'b0;
  logic [1:0]       action_i       = ActCtrl;
  logic [ByteW-1:0] data_i         = '0;
  logic [AddrW-1:0] load_address_i = '0;
  logic             busy;
  logic             done_o;
  logic [ByteW-1:0] control_stored_o;
  logic             read_valid_o;
  logic [ByteW-1:0] read_data_o;
  logic             interrupt_flag_o;
  logic             bad_address_o;
  int               errors;
  int               pending;

  // stimulus-side tracking so reads never hit unwritten storage
  logic [AddrW-1:0] sh_ptr = '0;
  int               wr_left = 0;
  bit               written [MemBytes];
  int               n_sent = 0;
  int               burst_left = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  i2c_eeprom_slave_model #(.MEMORY_BYTES(MemBytes)) uut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .data_i, .load_address_i,
    .done_o, .control_stored_o, .read_valid_o, .read_data_o,
    .interrupt_flag_o, .bad_address_o
  );

  i2cee_checker #(.MEM_BYTES(MemBytes)) u_checker (
    .clk_i, .rst_ni, .start, .busy, .action_i, .data_i, .load_address_i,
    .done_o, .control_stored_o, .read_valid_o, .read_data_o,
    .interrupt_flag_o, .bad_address_o, .errors, .pending
  );

  function automatic void track(input logic [1:0] act, input logic [ByteW-1:0] d,
                                input logic [AddrW-1:0] la);
    case (act)
      ActCtrl: if ((d & CondIdle) != 0) wr_left = 0;
      ActBuf: begin
        case (wr_left)
          0: begin
            if (d == DevRead) sh_ptr = (int'(sh_ptr) + 1 >= MemBytes) ? '0 : sh_ptr + 1'b1;
            else if (d == DevWrite) wr_left = 3;
          end
          3: begin
            sh_ptr  = (AddrW'(d) << 8) & AddrMask;
            wr_left = 2;
          end
          2: begin
            sh_ptr  = (sh_ptr | AddrW'(d)) & AddrMask;
            wr_left = 1;
          end
          default: begin
            written[sh_ptr % MemBytes] = 1'b1;
            wr_left = 0;
          end
        endcase
      end
      ActLoad: written[la % MemBytes] = 1'b1;
      default: ;
    endcase
  endfunction

  task automatic send(input logic [1:0] act, input logic [ByteW-1:0] d,
                      input logic [AddrW-1:0] la);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start          <= 1'b1;
    action_i       <= act;
    data_i         <= d;
    load_address_i <= la;
    do @(posedge clk_i); while (busy);
    track(act, d, la);
    n_sent++;
  endtask

  task automatic read_here();
    if (!written[sh_ptr % MemBytes]) send(ActLoad, ByteW'($urandom), sh_ptr);
    send(ActBuf, DevRead, AddrW'($urandom));
  endtask

  initial begin
    int target;
    int sel;
    logic [ByteW-1:0] d;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(ActCtrl, 8'h00, 12'h000);
    send(ActCtrl, 8'hFF, 12'hFFF);
    send(ActCtrl, BitAcken, 12'h000);
    send(ActCtrl, BitRcen, 12'h000);
    send(ActCtrl, BitPen, 12'h000);
    send(ActCtrl, BitRsen, 12'h000);
    send(ActCtrl, BitSen, 12'h000);
    send(ActCtrl, 8'hE0, 12'h000);
    // write at top address, read it back, pointer wraps to zero
    send(ActBuf, DevWrite, 12'h000);
    send(ActBuf, 8'hFF, 12'h000);
    send(ActBuf, 8'hFF, 12'h000);
    send(ActBuf, 8'h5A, 12'h000);
    send(ActBuf, DevRead, 12'h000);
    send(ActLoad, 8'hFF, 12'h000);
    send(ActLoad, 8'h00, 12'hFFF);
    send(ActBuf, DevRead, 12'hFFF);
    send(ActBuf, 8'h00, 12'h000);
    send(ActBuf, 8'hFF, 12'h000);
    send(ActNone, 8'hFF, 12'hFFF);
    // aborted writes
    send(ActBuf, DevWrite, 12'h000);
    send(ActBuf, 8'h12, 12'h000);
    send(ActCtrl, BitRsen, 12'h000);
    send(ActBuf, DevWrite, 12'h000);
    send(ActCtrl, BitPen, 12'h000);
    read_here();

    target = n_sent + RandomItems;
    while (n_sent < target) begin
      sel = $urandom_range(0, 99);
      if (wr_left != 0) begin
        d = ByteW'($urandom) | (($urandom_range(0, 1) == 0) ? BitPen : BitRsen);
        send(ActCtrl, d, AddrW'($urandom));
      end else if (sel < 35) begin
        send(ActBuf, DevWrite, AddrW'($urandom));
        repeat (3) begin
          if ($urandom_range(0, 9) == 0)
            send(ActCtrl, ByteW'($urandom) & ~CondIdle, AddrW'($urandom));
          send(ActBuf, ByteW'($urandom), AddrW'($urandom));
        end
      end else if (sel < 60) begin
        repeat ($urandom_range(1, 4)) read_here();
      end else if (sel < 70) begin
        send(ActLoad, ByteW'($urandom), AddrW'($urandom));
      end else if (sel < 80) begin
        send(ActCtrl, ByteW'($urandom), AddrW'($urandom));
      end else if (sel < 88) begin
        send(ActBuf, DevWrite, AddrW'($urandom));
        repeat ($urandom_range(0, 2)) send(ActBuf, ByteW'($urandom), AddrW'($urandom));
        d = ByteW'($urandom) | (($urandom_range(0, 1) == 0) ? BitPen : BitRsen);
        send(ActCtrl, d, AddrW'($urandom));
      end else if (sel < 94) begin
        do d = ByteW'($urandom); while (d == DevWrite || d == DevRead);
        send(ActBuf, d, AddrW'($urandom));
      end else begin
        send(ActNone, ByteW'($urandom), AddrW'($urandom));
      end
    end
    start <= 1'b0;

    for (int i = 0; i < 1000 && pending != 0; i++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

>>> files.f
rtl/core/i2cee_pkg.sv
rtl/core/i2cee_ram.sv
rtl/core/i2cee_ctrl.sv
rtl/core/i2c_eeprom_slave_model.sv
tb/sv/i2cee_checker.sv
tb/sv/tb_top.sv
